// ----- hdl/crm_pkg.sv -----
// ----------------------------------------------------------------------------
// crm_pkg
// Shared types and constants of the compression rate monitor.
// ----------------------------------------------------------------------------
package crm_pkg;

    // Field widths of one input and one result transaction
    localparam int SAMPLE_W    = 12;
    localparam int TIME_W      = 32;
    localparam int RATE_W      = 9;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;
    localparam int TIME_LSB    = SAMPLE_W;
    localparam int RATE_LSB    = 2;

    // Configuration port
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int REFR_W      = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_REFRACT   = 2'd1,
        REG_MIN_RATE  = 2'd2,
        REG_MAX_RATE  = 2'd3
    } cfg_reg_t;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = 12'd2000;
    localparam logic [REFR_W-1:0]   REFRACT_RST   = 16'd200;
    localparam logic [RATE_W-1:0]   MIN_RATE_RST  = 9'd100;
    localparam logic [RATE_W-1:0]   MAX_RATE_RST  = 9'd120;

    // Arithmetic constants
    localparam int                HISTORY_DEF = 10;
    localparam int                MS_PER_MIN  = 60000;
    localparam logic [RATE_W-1:0] RATE_SAT    = 9'd511;

endpackage

// ----- hdl/compression_rate_monitor_top.sv -----
// ----------------------------------------------------------------------------
// compression_rate_monitor_top
// Detects compressions in a sample stream and tracks their rate per minute.
// ----------------------------------------------------------------------------
// Every input transaction gives exactly one result transaction. A sample that
// is not a compression passes from S_EVAL to S_EMIT, which loads its result,
// with the held LED and rate, into the output register. A compression writes
// its timestamp into the stamp RAM; with fewer than two stored stamps it goes
// on from S_READ to S_EMIT. Otherwise the oldest stored stamp is read back: a
// zero span goes from S_SPAN straight to S_EMIT, and any other span runs a
// bit-serial restoring divider of NUM_W steps (20 at HISTORY = 10) followed
// by the multiply-compare steps S_CMPLO and S_CMPHI before S_EMIT, which
// holds until the output register is free. One item is worked on at a time
// and the next input can be taken in the cycle after a result is loaded. A
// new input is taken as soon as the previous result sits in the output
// register, even if that result has not been taken yet. The stamp RAM needs
// no clearing after reset, as only written entries are ever read.
module compression_rate_monitor_top
    import crm_pkg::*;
#(
    parameter int HISTORY = HISTORY_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] sample, [43:12] time_ms
    // Result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [0] led_on, [1] event_res, [10:2] rate_cpm
    // Configuration
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int IDX_W  = $clog2(HISTORY);
    localparam int CNT_W  = $clog2(HISTORY + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int NUM_W  = $clog2(MS_PER_MIN * (HISTORY - 1) + 1);
    localparam int DCNT_W = $clog2(NUM_W + 1);
    localparam int PROD_W = TIME_W + RATE_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_SPAN,
        S_DIV,
        S_CMPLO,
        S_CMPHI,
        S_EMIT
    } state_t;

    // Control state
    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      ws_reg, ws_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [TIME_W-1:0]     last_reg, last_next;
    logic                  led_reg, led_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic                  evt_reg, evt_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  mv_reg, mv_next;
    logic                  out_led_reg, out_led_next;
    logic                  out_evt_reg, out_evt_next;
    logic [RATE_W-1:0]     out_rate_reg, out_rate_next;

    // Configuration registers
    logic [SAMPLE_W-1:0]   thr_reg;
    logic [REFR_W-1:0]     refr_reg;
    logic [RATE_W-1:0]     min_reg;
    logic [RATE_W-1:0]     max_reg;

    // Datapath
    logic [SAMPLE_W-1:0]   sample_reg, sample_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [NUM_W-1:0]      numer_reg, numer_next;
    logic [TIME_W-1:0]     span_reg, span_next;
    logic [TIME_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]      quo_reg, quo_next;
    logic [NUM_W-1:0]      dvd_reg, dvd_next;
    logic                  lo_reg, lo_next;

    // Combinational helpers
    logic                  is_event;
    logic [TIME_W-1:0]     elapsed;
    logic [SUM_W-1:0]      oldest_sum;
    logic [IDX_W-1:0]      oldest_idx;
    logic [TIME_W-1:0]     span_now;
    logic [TIME_W:0]       rem_sh;
    logic                  rem_ge;
    logic [RATE_W-1:0]     mul_op;
    logic [PROD_W-1:0]     prod;
    logic [PROD_W-1:0]     numer_ext;

    // RAM ports
    logic                  ram_we;
    logic                  ram_re;
    logic [TIME_W-1:0]     ram_rdata;

    crm_ram #(
        .WIDTH (TIME_W),
        .DEPTH (HISTORY)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ws_reg),
        .wdata (time_reg),
        .re    (ram_re),
        .raddr (oldest_idx),
        .rdata (ram_rdata)
    );

    // Handshake and result packing
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mv_reg;
    assign m_tdata  = {{(OUT_TDATA_W - RATE_W - 2){1'b0}}, out_rate_reg, out_evt_reg,
                       out_led_reg};

    // Event test: above threshold and past the refractory window
    assign elapsed  = time_reg - last_reg;
    assign is_event = (sample_reg > thr_reg) && (elapsed > TIME_W'(refr_reg));

    // Oldest stored stamp sits count slots behind the write slot
    assign oldest_sum = SUM_W'(ws_reg) + SUM_W'(HISTORY) - SUM_W'(count_reg);
    assign oldest_idx = (oldest_sum >= SUM_W'(HISTORY)) ?
                        IDX_W'(oldest_sum - SUM_W'(HISTORY)) : IDX_W'(oldest_sum);

    // Span from the oldest stamp to the newest one
    assign span_now = time_reg - ram_rdata;

    // One restoring divide step
    assign rem_sh = {rem_reg, dvd_reg[NUM_W-1]};
    assign rem_ge = (rem_sh >= {1'b0, span_reg});

    // Shared rate-by-span multiplier for the range check
    assign mul_op    = (state_reg == S_CMPHI) ? max_reg : min_reg;
    assign prod      = PROD_W'(mul_op) * PROD_W'(span_reg);
    assign numer_ext = PROD_W'(numer_reg);

    // Next-state and datapath logic
    always_comb
    begin
        state_next    = state_reg;
        ws_next       = ws_reg;
        count_next    = count_reg;
        last_next     = last_reg;
        led_next      = led_reg;
        rate_next     = rate_reg;
        evt_next      = evt_reg;
        dcnt_next     = dcnt_reg;
        mv_next       = mv_reg;
        out_led_next  = out_led_reg;
        out_evt_next  = out_evt_reg;
        out_rate_next = out_rate_reg;
        sample_next   = sample_reg;
        time_next     = time_reg;
        numer_next    = numer_reg;
        span_next     = span_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        dvd_next      = dvd_reg;
        lo_next       = lo_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;

        // Drop the result once it is taken
        if (m_tready)
        begin
            mv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    sample_next = s_tdata[SAMPLE_W-1:0];
                    time_next   = s_tdata[TIME_LSB +: TIME_W];
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (is_event)
                begin
                    ram_we     = 1'b1;
                    ws_next    = (ws_reg == IDX_W'(HISTORY - 1)) ? '0 : ws_reg + IDX_W'(1);
                    count_next = (count_reg == CNT_W'(HISTORY)) ? count_reg :
                                 count_reg + CNT_W'(1);
                    last_next  = time_reg;
                    evt_next   = 1'b1;
                    state_next = S_READ;
                end
                else
                begin
                    evt_next   = 1'b0;
                    state_next = S_EMIT;
                end
            end
            S_READ:
            begin
                numer_next = NUM_W'(NUM_W'(MS_PER_MIN) * NUM_W'(count_reg - CNT_W'(1)));
                if (count_reg < CNT_W'(2))
                begin
                    rate_next  = '0;
                    led_next   = (min_reg != '0);
                    state_next = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                span_next = span_now;
                if (span_now == '0)
                begin
                    rate_next  = RATE_SAT;
                    led_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else
                begin
                    rem_next   = '0;
                    quo_next   = '0;
                    dvd_next   = numer_reg;
                    dcnt_next  = DCNT_W'(NUM_W);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                rem_next  = rem_ge ? TIME_W'(rem_sh - {1'b0, span_reg}) : TIME_W'(rem_sh);
                quo_next  = {quo_reg[NUM_W-2:0], rem_ge};
                dvd_next  = {dvd_reg[NUM_W-2:0], 1'b0};
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (dcnt_reg == DCNT_W'(1))
                begin
                    state_next = S_CMPLO;
                end
            end
            S_CMPLO:
            begin
                lo_next    = (numer_ext < prod);
                state_next = S_CMPHI;
            end
            S_CMPHI:
            begin
                led_next   = lo_reg || (numer_ext > prod);
                rate_next  = (quo_reg > NUM_W'(RATE_SAT)) ? RATE_SAT : quo_reg[RATE_W-1:0];
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // Hold until the output register is free
                if (!mv_reg || m_tready)
                begin
                    out_led_next  = led_reg;
                    out_evt_next  = evt_reg;
                    out_rate_next = rate_reg;
                    mv_next       = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ws_reg       <= '0;
            count_reg    <= '0;
            last_reg     <= '0;
            led_reg      <= 1'b0;
            rate_reg     <= '0;
            evt_reg      <= 1'b0;
            dcnt_reg     <= '0;
            mv_reg       <= 1'b0;
            out_led_reg  <= 1'b0;
            out_evt_reg  <= 1'b0;
            out_rate_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ws_reg       <= ws_next;
            count_reg    <= count_next;
            last_reg     <= last_next;
            led_reg      <= led_next;
            rate_reg     <= rate_next;
            evt_reg      <= evt_next;
            dcnt_reg     <= dcnt_next;
            mv_reg       <= mv_next;
            out_led_reg  <= out_led_next;
            out_evt_reg  <= out_evt_next;
            out_rate_reg <= out_rate_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        time_reg   <= time_next;
        numer_reg  <= numer_next;
        span_reg   <= span_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        dvd_reg    <= dvd_next;
        lo_reg     <= lo_next;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RST;
            refr_reg <= REFRACT_RST;
            min_reg  <= MIN_RATE_RST;
            max_reg  <= MAX_RATE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_THRESHOLD: thr_reg  <= cfg_wdata[SAMPLE_W-1:0];
                REG_REFRACT:   refr_reg <= cfg_wdata[REFR_W-1:0];
                REG_MIN_RATE:  min_reg  <= cfg_wdata[RATE_W-1:0];
                REG_MAX_RATE:  max_reg  <= cfg_wdata[RATE_W-1:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(HISTORY))
        else $error("stored stamp count above history depth");

    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        ws_reg < IDX_W'(HISTORY - 1) || ws_reg == IDX_W'(HISTORY - 1))
        else $error("write slot outside the ring");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> span_reg != '0)
        else $error("divider running on a zero span");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction taken while one is in flight");

    a_event_counted: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EVAL && is_event |=> count_reg != '0)
        else $error("compression recorded without a stored stamp");

endmodule

// ----- hdl/crm_ram.sv -----
// ----------------------------------------------------------------------------
// crm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- bench/tb_compression_rate_monitor_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_compression_rate_monitor_top
// Self-checking bench for the compression rate monitor.
// ----------------------------------------------------------------------------
// A short table of directed transactions and register writes runs first:
// threshold and refractory limits, the first stamp, a full ring with zero
// span, a minimum above the maximum, timestamp wrap and masked register
// values. Random phases follow, each with its own register setting and a
// train of compression pulses at a chosen period, mixed with noise. Every
// result is compared with its typed table value or a bit-exact model of the
// LED and rate logic kept here, while both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_compression_rate_monitor_top;
    import crm_pkg::*;

    localparam int ITEMS_TOTAL = 1750;
    localparam int SETTLE_CYC  = 40;

    typedef struct packed {
        logic              led;
        logic              ev;
        logic [RATE_W-1:0] rate;
    } led_rate_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t                kind;
        cfg_reg_t                 addr;
        logic [CFG_DATA_W-1:0]    value;
        logic [SAMPLE_W-1:0]      sample;
        logic [TIME_W-1:0]        stamp;
        bit                       typed;
        led_rate_t                res;
    } stim_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // [11:0] sample, [43:12] time_ms
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // [0] led_on, [1] event_res, [10:2] rate_cpm
    logic                   cfg_we;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    // Model copy of the registers and the stamp history
    logic [SAMPLE_W-1:0] thr_cfg;
    logic [REFR_W-1:0]   refr_cfg;
    logic [RATE_W-1:0]   min_cfg;
    logic [RATE_W-1:0]   max_cfg;
    logic [TIME_W-1:0]   stamps [HISTORY_DEF];
    int unsigned         slot;
    int unsigned         fill;
    logic [TIME_W-1:0]   last_stamp;
    logic                led_now;
    logic [RATE_W-1:0]   rate_now;

    led_rate_t   led_rate_q [$];
    stim_row_t   dir_tab [$];
    led_rate_t   want_res;
    bit          calm;
    int unsigned mismatches;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned events_seen;
    int unsigned sat_seen;
    int unsigned led_seen;
    int unsigned reg_writes;

    compression_rate_monitor_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    always #4 clk = ~clk;

    // Print one line per mismatch and count it
    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Advance the model by one sample and return the LED and rate it gives
    function automatic led_rate_t predict_led_rate(logic [SAMPLE_W-1:0] smp,
                                                   logic [TIME_W-1:0] now);
        led_rate_t         res;
        logic [TIME_W-1:0] elapsed;
        logic [TIME_W-1:0] diff;
        int unsigned       newest;
        int unsigned       oldest;
        logic [63:0]       numer;
        logic [63:0]       span;
        logic [63:0]       quo;
        elapsed = now - last_stamp;
        res.ev  = 1'b0;
        if (smp > thr_cfg && elapsed > {16'd0, refr_cfg}) begin
            res.ev       = 1'b1;
            stamps[slot] = now;
            slot         = (slot + 1) % HISTORY_DEF;
            if (fill < HISTORY_DEF)
                fill++;
            last_stamp = now;
            if (fill < 2) begin
                rate_now = '0;
                led_now  = (min_cfg != 0);
            end
            else begin
                newest = (slot + HISTORY_DEF - 1) % HISTORY_DEF;
                oldest = (slot + HISTORY_DEF - fill) % HISTORY_DEF;
                diff   = stamps[newest] - stamps[oldest];
                span   = {32'd0, diff};
                numer  = 64'(MS_PER_MIN) * 64'(fill - 1);
                // Zero span: rate unbounded
                if (span == 0) begin
                    rate_now = RATE_SAT;
                    led_now  = 1'b1;
                end
                else begin
                    quo      = numer / span;
                    rate_now = (quo > 64'(RATE_SAT)) ? RATE_SAT : quo[RATE_W-1:0];
                    led_now  = (numer < 64'(min_cfg) * span) || (numer > 64'(max_cfg) * span);
                end
            end
        end
        res.led  = led_now;
        res.rate = rate_now;
        return res;
    endfunction

    // Table rows: plain sample, sample with a typed result, register write
    function automatic stim_row_t it_row(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] t);
        stim_row_t r;
        r.kind   = ROW_ITEM;
        r.addr   = REG_THRESHOLD;
        r.value  = '0;
        r.sample = smp;
        r.stamp  = t;
        r.typed  = 1'b0;
        r.res    = '0;
        return r;
    endfunction

    function automatic stim_row_t ck_row(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] t,
                                         logic led, logic ev, int unsigned rate);
        stim_row_t r;
        r          = it_row(smp, t);
        r.typed    = 1'b1;
        r.res.led  = led;
        r.res.ev   = ev;
        r.res.rate = RATE_W'(rate);
        return r;
    endfunction

    function automatic stim_row_t cfg_row(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        stim_row_t r;
        r       = it_row('0, '0);
        r.kind  = ROW_CFG;
        r.addr  = idx;
        r.value = val;
        return r;
    endfunction

    // Write one register once nothing is outstanding; the enable is lowered
    // by the next sample transaction or at the end
    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 1'b0;
        while (led_rate_q.size() != 0)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_THRESHOLD: thr_cfg  = val[SAMPLE_W-1:0];
            REG_REFRACT:   refr_cfg = val[REFR_W-1:0];
            REG_MIN_RATE:  min_cfg  = val[RATE_W-1:0];
            REG_MAX_RATE:  max_cfg  = val[RATE_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    // Offer one sample transaction, after a random gap, and queue its result
    task automatic push_item(logic [SAMPLE_W-1:0] smp, logic [TIME_W-1:0] now,
                             bit typed, led_rate_t typed_res);
        led_rate_t pred;
        cfg_we <= 1'b0;
        if (!calm) begin
            while ($urandom_range(0, 99) < 37) begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'({now, smp});
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pred = predict_led_rate(smp, now);
        led_rate_q.push_back(typed ? typed_res : pred);
        items_sent++;
    endtask

    // Sample level above or not above the current threshold
    function automatic logic [SAMPLE_W-1:0] pick_sample(bit above);
        if (above && thr_cfg != '1)
            return SAMPLE_W'($urandom_range(int'(thr_cfg) + 1, 4095));
        return SAMPLE_W'($urandom_range(0, int'(thr_cfg)));
    endfunction

    // Result side: check each accepted transaction and stall at random
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (led_rate_q.size() == 0) begin
                report_mismatch("result with nothing expected", m_tdata, 0);
            end
            else begin
                want_res = led_rate_q.pop_front();
                if (m_tdata[0] !== want_res.led)
                    report_mismatch("led_on", m_tdata[0], want_res.led);
                if (m_tdata[1] !== want_res.ev)
                    report_mismatch("event_res", m_tdata[1], want_res.ev);
                if (m_tdata[RATE_LSB +: RATE_W] !== want_res.rate)
                    report_mismatch("rate_cpm", m_tdata[RATE_LSB +: RATE_W], want_res.rate);
            end
            events_seen += m_tdata[1];
            led_seen    += m_tdata[0];
            if (m_tdata[RATE_LSB +: RATE_W] == RATE_SAT)
                sat_seen++;
        end
        m_tready <= calm || ($urandom_range(0, 99) >= 37);
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("Timeout at %0t ns", $time);
        $display("Some tests failed");
        $finish;
    end

    // Stimulus
    initial begin
        logic [CFG_DATA_W-1:0] thr;
        logic [CFG_DATA_W-1:0] refr;
        logic [CFG_DATA_W-1:0] lo;
        logic [CFG_DATA_W-1:0] hi;
        logic [TIME_W-1:0]     cur_t;
        logic [TIME_W-1:0]     now;
        logic [SAMPLE_W-1:0]   smp;
        int unsigned           period;
        int unsigned           width;
        int unsigned           pos;
        int unsigned           step;
        int unsigned           step_max;
        int unsigned           phase_len;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = REG_THRESHOLD;
        cfg_wdata = '0;
        calm      = 1'b0;

        // Model at reset
        thr_cfg    = THRESHOLD_RST;
        refr_cfg   = REFRACT_RST;
        min_cfg    = MIN_RATE_RST;
        max_cfg    = MAX_RATE_RST;
        slot       = 0;
        fill       = 0;
        last_stamp = '0;
        led_now    = 1'b0;
        rate_now   = '0;
        foreach (stamps[k])
            stamps[k] = '0;

        dir_tab = '{
            // at or below the threshold: nothing changes
            ck_row(12'd0,    32'd0,    1'b0, 1'b0, 0),
            ck_row(12'd2000, 32'd5000, 1'b0, 1'b0, 0),
            // above the threshold but within the refractory time
            ck_row(12'd2001, 32'd150,  1'b0, 1'b0, 0),
            ck_row(12'd2001, 32'd200,  1'b0, 1'b0, 0),
            // first stamp gives no rate, so the LED lights
            ck_row(12'd4095, 32'd201,  1'b1, 1'b1, 0),
            ck_row(12'd4095, 32'd701,  1'b0, 1'b1, 120),
            ck_row(12'd4095, 32'd800,  1'b0, 1'b0, 120),
            ck_row(12'd4095, 32'd1201, 1'b0, 1'b1, 120),
            // no refractory time, bits above each register width dropped
            cfg_row(REG_REFRACT,   16'd0),
            cfg_row(REG_THRESHOLD, 16'hF000),
            cfg_row(REG_MIN_RATE,  16'd0),
            cfg_row(REG_MAX_RATE,  16'hFFFF),
            it_row(12'd1,    32'd1202),
            it_row(12'd0,    32'd5),
            it_row(12'd4095, 32'd1202),
            // highest threshold lets nothing through
            cfg_row(REG_REFRACT,   16'hFFFF),
            cfg_row(REG_THRESHOLD, 16'd4095),
            it_row(12'd4095, 32'hFFFF_FFFF),
            cfg_row(REG_THRESHOLD, 16'd0),
            // elapsed time across the wrap, just at and just past the limit
            it_row(12'd4095, 32'hFFFF_FFFF),
            it_row(12'd4095, 32'h0000_FFFE),
            it_row(12'd4095, 32'h0000_FFFF),
            it_row(12'd4095, 32'h4000_0000),
            it_row(12'd4095, 32'h8000_0000),
            it_row(12'd4095, 32'hC000_0000),
            // ring full with oldest equal to newest: zero span
            ck_row(12'd4095, 32'd201,  1'b1, 1'b1, 511),
            // minimum above maximum; oldest stamp now overwritten
            cfg_row(REG_MIN_RATE,  16'd300),
            cfg_row(REG_MAX_RATE,  16'd200),
            cfg_row(REG_REFRACT,   16'd0),
            it_row(12'd4095, 32'd202),
            it_row(12'd4095, 32'd60202),
            it_row(12'd4095, 32'd60203)
        };

        // Reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG)
                write_reg(dir_tab[k].addr, dir_tab[k].value);
            else
                push_item(dir_tab[k].sample, dir_tab[k].stamp, dir_tab[k].typed,
                          dir_tab[k].res);
        end

        // Random phases: a register setting, then a pulse train with noise
        cur_t = 32'd100_000;
        while (items_sent < ITEMS_TOTAL) begin
            case ($urandom_range(0, 5))
                3: begin
                    thr  = $urandom_range(0, 1) ? 16'd4095 : 16'd0;
                    refr = $urandom_range(0, 1) ? 16'hFFFF : 16'd0;
                    lo   = $urandom_range(0, 1) ? 16'd511  : 16'd0;
                    hi   = $urandom_range(0, 1) ? 16'd511  : 16'd0;
                end
                4: begin
                    thr  = CFG_DATA_W'($urandom());
                    refr = CFG_DATA_W'($urandom());
                    lo   = CFG_DATA_W'($urandom());
                    hi   = CFG_DATA_W'($urandom());
                end
                5: begin
                    thr  = CFG_DATA_W'($urandom_range(1500, 2500));
                    refr = CFG_DATA_W'($urandom_range(0, 300));
                    lo   = CFG_DATA_W'($urandom_range(200, 511));
                    hi   = CFG_DATA_W'($urandom_range(0, int'(lo) - 1));
                end
                default: begin
                    thr  = CFG_DATA_W'($urandom_range(1500, 2500));
                    refr = CFG_DATA_W'($urandom_range(100, 300));
                    lo   = CFG_DATA_W'($urandom_range(60, 120));
                    hi   = lo + CFG_DATA_W'($urandom_range(0, 60));
                end
            endcase
            write_reg(REG_THRESHOLD, thr);
            write_reg(REG_REFRACT, refr);
            write_reg(REG_MIN_RATE, lo);
            write_reg(REG_MAX_RATE, hi);

            case ($urandom_range(0, 9))
                6, 7:    period = $urandom_range(20, 150);
                8:       period = $urandom_range(1500, 6000);
                9:       period = $urandom_range(2, 20);
                default: period = $urandom_range(400, 800);
            endcase
            width     = $urandom_range(1, period / 3 + 1);
            step_max  = (period < 100) ? 4 : 15;
            pos       = 0;
            phase_len = $urandom_range(60, 180);
            // now and then start just short of the timestamp wrap
            if ($urandom_range(0, 5) == 0)
                cur_t = 32'hFFFF_FFFF - $urandom_range(0, 3000);

            repeat (phase_len) begin
                calm = (items_sent >= 700 && items_sent < 950);
                if ($urandom_range(0, 99) < 15) begin
                    smp = SAMPLE_W'($urandom());
                    case ($urandom_range(0, 2))
                        0:       now = $urandom();
                        1:       now = cur_t - $urandom_range(0, 500);
                        default: now = cur_t;
                    endcase
                    cur_t = now;
                end
                else begin
                    step  = $urandom_range(0, step_max);
                    cur_t = cur_t + step;
                    pos   = (pos + step) % period;
                    smp   = pick_sample(pos < width);
                    now   = cur_t;
                end
                push_item(smp, now, 1'b0, '0);
            end
        end
        calm = 1'b0;

        // Drain and let the block fall quiet
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (led_rate_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Checked %0d results from %0d samples across %0d register writes",
                 results_seen, items_sent, reg_writes);
        $display("Compressions %0d, results with LED lit %0d, saturated rates %0d",
                 events_seen, led_seen, sat_seen);
        if (mismatches == 0 && led_rate_q.size() == 0) begin
            $display("All tests passed");
        end
        else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
